### design/crc32f_pkg.sv
// ----------------------------------------------------------------------------
// crc32f_pkg: shared types and constants for the CRC-32 frame receiver
// Phase and result-kind codes, legacy command byte range, CRC-32 constants
// and the result bundle passed from the frame engine to the output stage.
// ----------------------------------------------------------------------------
package crc32f_pkg;

  // Receive phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEN_LOW = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_e;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_OK      = 3'd1,
    KIND_CRC_ERR = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_LEGACY  = 3'd4
  } kind_e;

  // Legacy command bytes: 'A'..'z' and '?'
  localparam logic [7:0] CMD_LO    = 8'h41;
  localparam logic [7:0] CMD_HI    = 8'h7A;
  localparam logic [7:0] CMD_QUERY = 8'h3F;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Timeout register reset value in milliseconds
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Number of trailing CRC bytes, minus one
  localparam logic [1:0] CRC_LAST_BYTE = 2'd3;

  // One result item
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
  } result_t;

endpackage

### design/crc32f_crc_byte.sv
// ----------------------------------------------------------------------------
// crc32f_crc_byte: bytewise reflected CRC-32 update
// Folds one byte into the running CRC, eight bit steps of shift and xor.
// ----------------------------------------------------------------------------
module crc32f_crc_byte
  import crc32f_pkg::*;
(
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  // Shift out one bit per step, xor the polynomial when the low bit is set
  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

### design/crc32f_frame_fsm.sv
// ----------------------------------------------------------------------------
// crc32f_frame_fsm: frame parsing state, CRC and timeout tracking
// Holds the receive phase and frame registers, updates them on each accepted
// item and forms the result that the item causes.
// ----------------------------------------------------------------------------
module crc32f_frame_fsm
  import crc32f_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output result_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [15:0] payload_length_q, payload_length_d;
  logic [15:0] bytes_seen_q, bytes_seen_d;
  logic [31:0] running_crc_q, running_crc_d;
  logic [31:0] received_crc_q, received_crc_d;
  logic [1:0]  crc_cnt_q, crc_cnt_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] timeout_q;

  logic [31:0] crc_next;
  logic [15:0] len_full;
  logic [15:0] seen_inc;
  logic [31:0] recv_shift;
  logic        is_cmd;
  logic        timed_out;

  crc32f_crc_byte u_crc (
    .crc_i  (running_crc_q),
    .byte_i (rx_byte_i),
    .crc_o  (crc_next)
  );

  assign len_full   = {length_high_q, rx_byte_i};
  assign seen_inc   = bytes_seen_q + 16'd1;
  assign recv_shift = {received_crc_q[23:0], rx_byte_i};
  assign is_cmd     = ((rx_byte_i >= CMD_LO) && (rx_byte_i <= CMD_HI))
                      || (rx_byte_i == CMD_QUERY);
  assign timed_out  = (elapsed_q >= timeout_q);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (mode_i) begin
        if ((phase_q != PH_IDLE) && timed_out) begin
          phase_d = PH_IDLE;
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (!is_cmd) phase_d = PH_LEN_LOW;
          end
          PH_LEN_LOW: begin
            phase_d = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (seen_inc == payload_length_q) phase_d = PH_CRC;
          end
          PH_CRC: begin
            if (crc_cnt_q == CRC_LAST_BYTE) phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Frame registers and result
  always_comb begin
    length_high_d    = length_high_q;
    payload_length_d = payload_length_q;
    bytes_seen_d     = bytes_seen_q;
    running_crc_d    = running_crc_q;
    received_crc_d   = received_crc_q;
    crc_cnt_d        = crc_cnt_q;
    elapsed_d        = elapsed_q;
    res_o            = '0;
    res_o.kind       = KIND_PAYLOAD;
    if (fire_i) begin
      if (mode_i) begin
        // Tick: abandon on timeout, else count
        if (phase_q != PH_IDLE) begin
          if (timed_out) begin
            res_o.valid = 1'b1;
            res_o.kind  = KIND_TIMEOUT;
          end else begin
            elapsed_d = elapsed_q + 16'd1;
          end
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (is_cmd) begin
              res_o.valid     = 1'b1;
              res_o.kind      = KIND_LEGACY;
              res_o.data_byte = rx_byte_i;
            end else begin
              length_high_d = rx_byte_i;
              elapsed_d     = '0;
            end
          end
          PH_LEN_LOW: begin
            payload_length_d = len_full;
            bytes_seen_d     = '0;
            running_crc_d    = CRC_INIT;
            received_crc_d   = '0;
            crc_cnt_d        = '0;
          end
          PH_PAYLOAD: begin
            res_o.valid        = 1'b1;
            res_o.kind         = KIND_PAYLOAD;
            res_o.data_byte    = rx_byte_i;
            res_o.byte_index   = bytes_seen_q;
            res_o.frame_length = payload_length_q;
            running_crc_d      = crc_next;
            bytes_seen_d       = seen_inc;
            if (seen_inc == payload_length_q) begin
              crc_cnt_d      = '0;
              received_crc_d = '0;
            end
          end
          PH_CRC: begin
            received_crc_d = recv_shift;
            crc_cnt_d      = crc_cnt_q + 2'd1;
            if (crc_cnt_q == CRC_LAST_BYTE) begin
              res_o.valid        = 1'b1;
              res_o.frame_length = payload_length_q;
              res_o.kind         = (recv_shift == ~running_crc_q) ? KIND_OK
                                                                  : KIND_CRC_ERR;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_IDLE;
      length_high_q    <= '0;
      payload_length_q <= '0;
      bytes_seen_q     <= '0;
      running_crc_q    <= CRC_INIT;
      received_crc_q   <= '0;
      crc_cnt_q        <= '0;
      elapsed_q        <= '0;
    end else begin
      phase_q          <= phase_d;
      length_high_q    <= length_high_d;
      payload_length_q <= payload_length_d;
      bytes_seen_q     <= bytes_seen_d;
      running_crc_q    <= running_crc_d;
      received_crc_q   <= received_crc_d;
      crc_cnt_q        <= crc_cnt_d;
      elapsed_q        <= elapsed_d;
    end
  end

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

`ifndef SYNTH
  // A timeout or a finished frame returns to idle
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == KIND_TIMEOUT || res_o.kind == KIND_OK
     || res_o.kind == KIND_CRC_ERR)) |=> (phase_q == PH_IDLE))
    else $error("frame end did not return to idle");

  // Payload byte index stays inside the frame
  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_PAYLOAD)
    |-> (res_o.byte_index < res_o.frame_length))
    else $error("payload index outside frame");

  // Leaving payload phase starts a fresh CRC byte count
  a_crc_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD && phase_d == PH_CRC) |=> (crc_cnt_q == 2'd0))
    else $error("CRC byte count not cleared");
`endif

endmodule

### design/crc32f_out_reg.sv
// ----------------------------------------------------------------------------
// crc32f_out_reg: result output register
// Captures a result on an accepted item and holds it until the transfer.
// ----------------------------------------------------------------------------
module crc32f_out_reg
  import crc32f_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     res_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] frame_length_o
);

  logic    valid_q;
  result_t data_q;

  // Advance valid: set on load, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && res_i.valid) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = data_q.kind;
  assign data_byte_o    = data_q.data_byte;
  assign byte_index_o   = data_q.byte_index;
  assign frame_length_o = data_q.frame_length;

endmodule

### design/crc32_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// crc32_frame_receiver_core: length-prefixed frame receiver with CRC-32 check
// Parses legacy command bytes and length-prefixed frames, passes payload bytes
// on with their index, checks the trailing CRC-32 and times out on ticks.
//
//   channel | signals                                  | direction
//   in      | in_valid_i, in_ready_o, mode_i, rx_byte_i | to block
//   out     | out_valid_o, out_ready_i, kind_o,         | from block
//           | data_byte_o, byte_index_o, frame_length_o |
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i      | to block
//
// One item per cycle while the input is not stalled; its result is registered
// in the output register and appears in the cycle after the input transfer.
// Reset puts the receiver in idle with a 500 ms timeout.
// The input stalls only while a result waits in the output register and the
// sink is not ready; cfg is always ready.
// ----------------------------------------------------------------------------
module crc32_frame_receiver_core
  import crc32f_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic    in_fire;
  result_t res;

  // Accept when the output register is free or drains this cycle
  assign in_ready_o  = !out_valid_o || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  crc32f_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res)
  );

  crc32f_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_fire),
    .res_i          (res),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o)
  );

`ifndef SYNTH
  // An empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // A transfer that causes a result shows it in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.valid) |=> out_valid_o)
    else $error("result lost");

  // Without a new result a transferred output goes away
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !(in_fire && res.valid)) |=> !out_valid_o)
    else $error("result repeated");
`endif

endmodule
